FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the deque filter block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with active-low reset disable
`define ASSERT_CLK(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// Assertion on the block's own clk and rst_n
`define ASSERT_BDNF(lbl, prop, msg) \
    `ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

FILE: src/bdnf_pkg.sv
// ----------------------------------------------------------------------------
// bdnf_pkg
// Types and constants for the bounded deque neighbor filter.
// ----------------------------------------------------------------------------
package bdnf_pkg;

    localparam int DEPTH  = 32;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_PUSH_F = 3'd0,
        CMD_PUSH_B = 3'd1,
        CMD_POP_F  = 3'd2,
        CMD_POP_B  = 3'd3,
        CMD_READ_F = 3'd4,
        CMD_READ_B = 3'd5,
        CMD_SEARCH = 3'd6,
        CMD_FILTER = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_LISTED  = 3'd0,
        KIND_POPPED  = 3'd1,
        KIND_FOUND   = 3'd2,
        KIND_NORIGHT = 3'd3,
        KIND_REMOVED = 3'd4,
        KIND_END     = 3'd5,
        KIND_EMPTY   = 3'd6,
        KIND_FULL    = 3'd7
    } kind_t;

    // What the whole cell row does in one cycle
    typedef enum logic [2:0] {
        CH_HOLD   = 3'd0,
        CH_ROT_L  = 3'd1,
        CH_ROT_R  = 3'd2,
        CH_PUSH_F = 3'd3,
        CH_PUSH_B = 3'd4,
        CH_DROP   = 3'd5
    } chain_mode_t;

    // What a single cell loads
    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_LEFT  = 2'd1,
        OP_RIGHT = 2'd2,
        OP_LOAD  = 2'd3
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_ALIGN  = 2'd2,
        ST_FINISH = 2'd3
    } state_t;

    typedef struct packed {
        chain_mode_t         mode;
        logic [CNT_W-1:0]    bound;
        logic [DATA_W-1:0]   load_val;
    } chain_ctl_t;

    typedef struct packed {
        kind_t               kind;
        logic [DATA_W-1:0]   item_value;
        logic [DATA_W-1:0]   neighbor_value;
    } result_t;

endpackage

FILE: src/bdnf_cell.sv
// ----------------------------------------------------------------------------
// bdnf_cell
// One entry of the cell row: holds a value or takes a neighbor or the operand.
// ----------------------------------------------------------------------------
module bdnf_cell
    import bdnf_pkg::*;
(
    input  logic              clk,
    input  cell_op_t          op,
    input  logic [DATA_W-1:0] left_val,
    input  logic [DATA_W-1:0] right_val,
    input  logic [DATA_W-1:0] load_val,
    output logic [DATA_W-1:0] val
);

    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;

    always_comb
    begin
        unique case (op)
            OP_HOLD:  val_next = val_reg;
            OP_LEFT:  val_next = left_val;
            OP_RIGHT: val_next = right_val;
            OP_LOAD:  val_next = load_val;
            default:  val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

FILE: src/bdnf_chain.sv
// ----------------------------------------------------------------------------
// bdnf_chain
// Circular row of DEPTH cells; decodes the row mode into per-cell loads.
// ----------------------------------------------------------------------------
module bdnf_chain
    import bdnf_pkg::*;
(
    input  logic              clk,
    input  chain_ctl_t        ctl,
    output logic [DATA_W-1:0] head,
    output logic [DATA_W-1:0] second,
    output logic [DATA_W-1:0] tail
);

    logic [DATA_W-1:0] vals [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam int L = (i == 0) ? DEPTH - 1 : i - 1;
        localparam int R = (i == DEPTH - 1) ? 0 : i + 1;

        cell_op_t op;

        always_comb
        begin
            unique case (ctl.mode)
                CH_HOLD:   op = OP_HOLD;
                CH_ROT_L:  op = OP_RIGHT;
                CH_ROT_R:  op = OP_LEFT;
                CH_PUSH_F: op = (i == 0) ? OP_LOAD : OP_LEFT;
                CH_PUSH_B: op = (CNT_W'(i) == ctl.bound) ? OP_LOAD : OP_HOLD;
                // close the gap below the bound, keep the packed survivors above it
                CH_DROP:   op = (CNT_W'(i) < ctl.bound) ? OP_RIGHT : OP_HOLD;
                default:   op = OP_HOLD;
            endcase
        end

        bdnf_cell u_cell (
            .clk       (clk),
            .op        (op),
            .left_val  (vals[L]),
            .right_val (vals[R]),
            .load_val  (ctl.load_val),
            .val       (vals[i])
        );
    end

    assign head   = vals[0];
    assign second = vals[1];
    assign tail   = vals[DEPTH-1];

endmodule

FILE: src/bounded_deque_neighbor_filter_unit.sv
// ----------------------------------------------------------------------------
// bounded_deque_neighbor_filter_unit
// Bounded deque with list, neighbor search and neighbor filter commands.
// ----------------------------------------------------------------------------
// Push: the next command is accepted in the following cycle.
// Pop front, full and empty: the result goes to the pending register, then to the output register.
// Pop back, reads and search: the cell row rotates one position per cycle while the
//   output can take a result, and every entry passes the head or tail cell.
// Filter: walk over the entries, then a realign rotation.
// Reset clears count, state and valid flags; cell contents stay undefined.
`include "assert_macros.svh"

module bounded_deque_neighbor_filter_unit
    import bdnf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] operand_value
    input  logic [2:0]  s_axis_tuser,   // [2:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] item_value, [63:32] neighbor_value
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast    // last_of_run
);

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  step_reg, step_next;
    logic [CNT_W-1:0]  kept_reg, kept_next;
    logic [DATA_W-1:0] key_reg, key_next;
    logic [DATA_W-1:0] left_reg, left_next;
    logic              pend_valid_reg, pend_valid_next;
    result_t           pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_last_reg, out_last_next;
    result_t           out_reg, out_next;

    chain_ctl_t        chain_ctl;
    logic [DATA_W-1:0] head, second, tail;
    logic              out_free;
    cmd_t              in_cmd;

    bdnf_chain u_chain (
        .clk    (clk),
        .ctl    (chain_ctl),
        .head   (head),
        .second (second),
        .tail   (tail)
    );

    assign in_cmd        = cmd_t'(s_axis_tuser);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        logic [CNT_W-1:0]   k_back;
        logic [CNT_W-1:0]   kept_new;
        logic signed [DATA_W:0] sum_ext;
        logic signed [DATA_W:0] cur_ext;
        logic               is_end;
        logic               remove;
        logic               r_valid;
        result_t            r;

        state_next      = state_reg;
        cmd_next        = cmd_reg;
        cnt_next        = cnt_reg;
        step_next       = step_reg;
        kept_next       = kept_reg;
        key_next        = key_reg;
        left_next       = left_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_last_next   = out_last_reg;
        out_next        = out_reg;
        chain_ctl       = '{mode: CH_HOLD, bound: '0, load_val: s_axis_tdata};

        k_back   = CNT_W'(DEPTH - 1) - step_reg;
        sum_ext  = $signed({left_reg[DATA_W-1], left_reg})
                 + $signed({second[DATA_W-1], second});
        cur_ext  = $signed({head[DATA_W-1], head});
        is_end   = (step_reg == '0) || (step_reg == cnt_reg - CNT_W'(1));
        remove   = !is_end && (cur_ext < sum_ext);
        kept_new = remove ? kept_reg : kept_reg + CNT_W'(1);
        r_valid  = 1'b0;
        r        = '{kind: KIND_LISTED, item_value: '0, neighbor_value: '0};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next  = in_cmd;
                    key_next  = s_axis_tdata;
                    step_next = '0;
                    kept_next = '0;
                    left_next = '0;
                    priority if (in_cmd == CMD_PUSH_F || in_cmd == CMD_PUSH_B)
                    begin
                        if (cnt_reg == CNT_W'(DEPTH))
                        begin
                            pend_valid_next = 1'b1;
                            pend_next = '{kind: KIND_FULL, item_value: s_axis_tdata,
                                          neighbor_value: '0};
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            chain_ctl.mode  = (in_cmd == CMD_PUSH_F) ? CH_PUSH_F : CH_PUSH_B;
                            chain_ctl.bound = cnt_reg;
                            cnt_next        = cnt_reg + CNT_W'(1);
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        pend_valid_next = 1'b1;
                        pend_next = '{kind: KIND_EMPTY, item_value: '0, neighbor_value: '0};
                        state_next = ST_FINISH;
                    end
                    else if (in_cmd == CMD_POP_F)
                    begin
                        pend_valid_next = 1'b1;
                        pend_next = '{kind: KIND_POPPED, item_value: head, neighbor_value: '0};
                        chain_ctl.mode = CH_ROT_L;
                        cnt_next   = cnt_reg - CNT_W'(1);
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (out_free)
                begin
                    step_next = step_reg + CNT_W'(1);
                    unique case (cmd_reg)
                        CMD_READ_F, CMD_POP_B, CMD_SEARCH:
                        begin
                            chain_ctl.mode = CH_ROT_L;
                            if (cmd_reg == CMD_READ_F)
                            begin
                                r_valid = step_reg < cnt_reg;
                                r = '{kind: KIND_LISTED, item_value: head, neighbor_value: '0};
                            end
                            else if (cmd_reg == CMD_POP_B)
                            begin
                                r_valid = step_reg == cnt_reg - CNT_W'(1);
                                r = '{kind: KIND_POPPED, item_value: head, neighbor_value: '0};
                            end
                            else
                            begin
                                r_valid = (step_reg < cnt_reg) && (head == key_reg);
                                if (step_reg + CNT_W'(1) < cnt_reg)
                                    r = '{kind: KIND_FOUND, item_value: key_reg,
                                          neighbor_value: second};
                                else
                                    r = '{kind: KIND_NORIGHT, item_value: key_reg,
                                          neighbor_value: '0};
                            end
                            if (step_reg == CNT_W'(DEPTH - 1))
                            begin
                                if (cmd_reg == CMD_POP_B)
                                    cnt_next = cnt_reg - CNT_W'(1);
                                state_next = ST_FINISH;
                            end
                        end
                        CMD_READ_B:
                        begin
                            chain_ctl.mode = CH_ROT_R;
                            r_valid = k_back < cnt_reg;
                            r = '{kind: KIND_LISTED, item_value: tail, neighbor_value: '0};
                            if (step_reg == CNT_W'(DEPTH - 1))
                                state_next = ST_FINISH;
                        end
                        CMD_FILTER:
                        begin
                            r_valid = is_end || remove;
                            r = '{kind: remove ? KIND_REMOVED : KIND_END,
                                  item_value: head, neighbor_value: '0};
                            // survivors pack into the top kept cells
                            if (remove)
                            begin
                                chain_ctl.mode  = CH_DROP;
                                chain_ctl.bound = CNT_W'(DEPTH - 1) - kept_reg;
                            end
                            else
                            begin
                                chain_ctl.mode = CH_ROT_L;
                                left_next      = head;
                            end
                            kept_next = kept_new;
                            if (step_reg == cnt_reg - CNT_W'(1))
                            begin
                                cnt_next   = kept_new;
                                step_next  = '0;
                                state_next = (kept_new == CNT_W'(DEPTH)) ? ST_FINISH : ST_ALIGN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase

                    // hold one result back so the last one can carry tlast
                    if (r_valid)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_next       = pend_reg;
                            out_last_next  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = r;
                    end
                end
            end

            ST_ALIGN:
            begin
                // rotate the packed survivors back down to cell zero
                chain_ctl.mode = CH_ROT_L;
                step_next      = step_reg + CNT_W'(1);
                if (step_reg == CNT_W'(DEPTH) - cnt_reg - CNT_W'(1))
                    state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_next        = pend_reg;
                        out_last_next   = 1'b1;
                        out_valid_next  = 1'b1;
                        pend_valid_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cmd_reg        <= CMD_PUSH_F;
            cnt_reg        <= '0;
            step_reg       <= '0;
            kept_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            cnt_reg        <= cnt_next;
            step_reg       <= step_next;
            kept_reg       <= kept_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        left_reg     <= left_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.neighbor_value, out_reg.item_value};
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_last_reg;

    `ASSERT_BDNF(a_cnt_bounded, (cnt_reg <= CNT_W'(DEPTH)), "entry count above depth")
    `ASSERT_BDNF(a_idle_no_pending, (s_axis_tready |-> !pend_valid_reg), "pending result in idle")
    `ASSERT_BDNF(a_flush_last, ((state_reg == ST_FINISH && out_free && pend_valid_reg) |=> (m_axis_tvalid && m_axis_tlast)), "final result not flagged last")
    `ASSERT_BDNF(a_full_push_keeps_cnt, ((s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_PUSH_F || s_axis_tuser == CMD_PUSH_B) && cnt_reg == CNT_W'(DEPTH)) |=> $stable(cnt_reg)), "push into full deque changed count")
    `ASSERT_BDNF(a_align_not_full, ((state_reg == ST_ALIGN) |-> (cnt_reg < CNT_W'(DEPTH))), "realign with no gap")

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded deque neighbor filter. A queue of
// commands feeds a stream driver with random gaps; a shadow deque predicts
// every result, and a monitor with random back-pressure checks each result
// transaction in order against it.
// ----------------------------------------------------------------------------
module testbench;
    import bdnf_pkg::*;

    localparam int RAND_ITEMS  = 200;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        cmd_t        cmd;
        logic [31:0] operand;
    } command_t;

    typedef struct {
        kind_t       kind;
        logic [31:0] item;
        logic [31:0] nbr;
        logic        last;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    command_t    pending_cmds[$];
    outcome_t    expected_results[$];

    // Shadow deque
    logic [31:0] shadow_store [DEPTH];
    int          shadow_front;
    int          shadow_count;

    int          errors;
    int          cycle_count;
    int          send_gap;
    int          stall_left;
    bit          no_idle;
    bit          in_fire;

    bounded_deque_neighbor_filter_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int slot_of(int k);
        return (shadow_front + k) % DEPTH;
    endfunction

    // Update the shadow deque for one accepted command and queue its results
    function void apply_command(command_t c);
        outcome_t           run[$];
        outcome_t           r;
        logic [31:0]        cur;
        logic [31:0]        left;
        logic [31:0]        right;
        logic signed [32:0] sum;
        int                 kept;
        run.delete();
        r.nbr  = '0;
        r.last = 1'b0;
        if (c.cmd == CMD_PUSH_F || c.cmd == CMD_PUSH_B) begin
            if (shadow_count >= DEPTH) begin
                r.kind = KIND_FULL;
                r.item = c.operand;
                run.push_back(r);
            end else if (c.cmd == CMD_PUSH_F) begin
                shadow_front = (shadow_front == 0) ? DEPTH - 1 : shadow_front - 1;
                shadow_store[shadow_front] = c.operand;
                shadow_count++;
            end else begin
                shadow_store[slot_of(shadow_count)] = c.operand;
                shadow_count++;
            end
        end else if (shadow_count == 0) begin
            r.kind = KIND_EMPTY;
            r.item = '0;
            run.push_back(r);
        end else begin
            case (c.cmd)
                CMD_POP_F:
                begin
                    r.kind = KIND_POPPED;
                    r.item = shadow_store[shadow_front];
                    run.push_back(r);
                    shadow_front = slot_of(1);
                    shadow_count--;
                end
                CMD_POP_B:
                begin
                    r.kind = KIND_POPPED;
                    r.item = shadow_store[slot_of(shadow_count - 1)];
                    run.push_back(r);
                    shadow_count--;
                end
                CMD_READ_F:
                begin
                    r.kind = KIND_LISTED;
                    for (int k = 0; k < shadow_count; k++) begin
                        r.item = shadow_store[slot_of(k)];
                        run.push_back(r);
                    end
                end
                CMD_READ_B:
                begin
                    r.kind = KIND_LISTED;
                    for (int k = shadow_count - 1; k >= 0; k--) begin
                        r.item = shadow_store[slot_of(k)];
                        run.push_back(r);
                    end
                end
                CMD_SEARCH:
                begin
                    for (int k = 0; k < shadow_count; k++) begin
                        if (shadow_store[slot_of(k)] == c.operand) begin
                            r.item = c.operand;
                            if (k + 1 < shadow_count) begin
                                r.kind = KIND_FOUND;
                                r.nbr  = shadow_store[slot_of(k + 1)];
                            end else begin
                                r.kind = KIND_NORIGHT;
                                r.nbr  = '0;
                            end
                            run.push_back(r);
                        end
                    end
                end
                default:
                begin
                    // Compare against left survivor plus original right at 33 bits;
                    // pack survivors toward the front as the walk goes.
                    kept = 0;
                    left = '0;
                    for (int k = 0; k < shadow_count; k++) begin
                        cur = shadow_store[slot_of(k)];
                        if (k == 0 || k == shadow_count - 1) begin
                            r.kind = KIND_END;
                            r.item = cur;
                            run.push_back(r);
                        end else begin
                            right = shadow_store[slot_of(k + 1)];
                            sum = $signed({left[31], left}) + $signed({right[31], right});
                            if ($signed({cur[31], cur}) < sum) begin
                                r.kind = KIND_REMOVED;
                                r.item = cur;
                                run.push_back(r);
                                continue;
                            end
                        end
                        shadow_store[slot_of(kept)] = cur;
                        kept++;
                        left = cur;
                    end
                    shadow_count = kept;
                end
            endcase
        end
        if (run.size() > 0)
            run[run.size() - 1].last = 1'b1;
        foreach (run[i])
            expected_results.push_back(run[i]);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (no_idle || r < 5)
            return 0;
        if (r < 9)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Mostly a narrow band around zero so searches hit and the filter decides both ways
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return $urandom;
            default: return $urandom_range(0, 8) - 32'd4;
        endcase
    endfunction

    task automatic add_cmd(cmd_t c, logic [31:0] v);
        command_t t;
        t.cmd     = c;
        t.operand = v;
        pending_cmds.push_back(t);
    endtask

    // Hold until every queued command has been accepted
    task automatic wait_sent();
        while (pending_cmds.size() > 0 || s_axis_tvalid)
            @(posedge clk);
    endtask

    // Driver: present commands at the falling edge, gap after each transaction
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_fire)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                s_axis_tuser  <= pending_cmds[0].cmd;
                s_axis_tdata  <= pending_cmds[0].operand;
                s_axis_tvalid <= 1'b1;
                void'(pending_cmds.pop_front());
                send_gap = pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Monitor: check results first, then predict the command accepted at this edge
    always @(posedge clk)
    begin : monitor
        outcome_t want;
        command_t got_cmd;
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: kind %0d item_value %h",
                           m_axis_tuser, m_axis_tdata[31:0]);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tuser !== want.kind) begin
                        $error("kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tdata[31:0] !== want.item) begin
                        $error("item_value: expected %h, actual %h",
                               want.item, m_axis_tdata[31:0]);
                        errors++;
                    end
                    if (m_axis_tdata[63:32] !== want.nbr) begin
                        $error("neighbor_value: expected %h, actual %h",
                               want.nbr, m_axis_tdata[63:32]);
                        errors++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last_of_run: expected %0b, actual %0b",
                               want.last, m_axis_tlast);
                        errors++;
                    end
                end
            end
            in_fire = s_axis_tvalid && s_axis_tready;
            if (in_fire) begin
                got_cmd.cmd     = cmd_t'(s_axis_tuser);
                got_cmd.operand = s_axis_tdata;
                apply_command(got_cmd);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : stimulus
        int n;
        int rand_sent;
        int settle;
        logic [31:0] key;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_PUSH_F;
        m_axis_tready = 1'b0;
        errors        = 0;
        cycle_count   = 0;
        send_gap      = 0;
        stall_left    = 0;
        no_idle       = 1'b0;
        in_fire       = 1'b0;
        shadow_front  = 0;
        shadow_count  = 0;
        rand_sent     = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Every command but push on an empty deque
        add_cmd(CMD_POP_F, '0);
        add_cmd(CMD_POP_B, '0);
        add_cmd(CMD_READ_F, '0);
        add_cmd(CMD_READ_B, '0);
        add_cmd(CMD_SEARCH, '0);
        add_cmd(CMD_FILTER, '0);
        // Filter of a single entry
        add_cmd(CMD_PUSH_B, 32'h7fff_ffff);
        add_cmd(CMD_FILTER, '0);
        // Extremes: a sum past the 32-bit range must not wrap in either direction
        add_cmd(CMD_PUSH_B, 32'h7fff_ffff);
        add_cmd(CMD_PUSH_B, 32'h7fff_ffff);
        add_cmd(CMD_PUSH_F, 32'h8000_0000);
        add_cmd(CMD_PUSH_F, 32'h8000_0000);
        add_cmd(CMD_PUSH_F, 32'h8000_0000);
        add_cmd(CMD_READ_F, '0);
        add_cmd(CMD_READ_B, '0);
        add_cmd(CMD_SEARCH, 32'h7fff_ffff);
        add_cmd(CMD_SEARCH, '0);
        add_cmd(CMD_FILTER, '0);
        add_cmd(CMD_READ_F, '0);
        add_cmd(CMD_POP_F, '0);
        add_cmd(CMD_POP_B, '0);
        add_cmd(CMD_PUSH_F, '0);
        add_cmd(CMD_PUSH_B, 32'hffff_ffff);
        add_cmd(CMD_SEARCH, 32'hffff_ffff);
        add_cmd(CMD_READ_B, '0);
        wait_sent();

        while (rand_sent < RAND_ITEMS) begin
            no_idle = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0:
                begin
                    // Fill past full
                    n = DEPTH - shadow_count + $urandom_range(1, 3);
                    for (int i = 0; i < n; i++)
                        add_cmd($urandom_range(0, 1) ? CMD_PUSH_B : CMD_PUSH_F, pick_value());
                end
                1:
                begin
                    // Drain past empty
                    n = shadow_count + 1;
                    for (int i = 0; i < n; i++)
                        add_cmd($urandom_range(0, 1) ? CMD_POP_B : CMD_POP_F, '0);
                end
                2, 3, 4:
                begin
                    n = $urandom_range(4, 10);
                    for (int i = 0; i < n; i++)
                        add_cmd(cmd_t'($urandom_range(0, 7)), pick_value());
                end
                default:
                begin
                    // Build a short run, then inspect or filter it
                    n = $urandom_range(2, 8);
                    for (int i = 0; i < n; i++)
                        add_cmd($urandom_range(0, 1) ? CMD_PUSH_B : CMD_PUSH_F, pick_value());
                    for (int i = $urandom_range(1, 3); i > 0; i--) begin
                        key = pick_value();
                        add_cmd(cmd_t'($urandom_range(CMD_READ_F, CMD_FILTER)), key);
                        n++;
                    end
                end
            endcase
            rand_sent += n;
            wait_sent();
        end

        no_idle = 1'b0;
        while (expected_results.size() > 0)
            @(posedge clk);
        settle = 2 * DEPTH + 8;
        repeat (settle) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
